>>> rtl/rli_pkg.sv
// shared constants, codes and handshake structs for the run length index lookup
package rli_pkg;

	localparam int MAX_RUNS        = 256;
	localparam int RUN_LENGTH_BITS = 16;

	localparam int IDX_BITS        = $clog2(MAX_RUNS);
	localparam int CNT_BITS        = $clog2(MAX_RUNS + 1);
	localparam int POS_BITS        = 24;
	localparam int TOTAL_BITS      = 24;
	localparam int ACC_BITS        = IDX_BITS + RUN_LENGTH_BITS;
	localparam int CMP_BITS        = (ACC_BITS > POS_BITS) ? ACC_BITS : POS_BITS;
	localparam int RUN_INDEX_BITS  = 8;
	localparam int RUNS_HELD_BITS  = 9;
	localparam int IN_LEN_BITS     = 16;

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	typedef struct packed {
		logic                start;
		logic [POS_BITS-1:0] pos;
		logic [CNT_BITS-1:0] count;
	} walk_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [IDX_BITS-1:0] idx;
		logic                beyond;
	} walk_rsp_t;

endpackage

>>> rtl/run_length_index_lookup.sv
// top level of the run length table with element position lookup
//
// Each input word carries a command. Clear and append take effect when the word is
// accepted and their result word is ready on the next cycle. A lookup walks the stored runs
// in order, one run per cycle through a single adder and comparator fed by the
// registered read port of the run store, and stops at the first run that covers the
// position or after the last stored run (a full table holds 256 runs). A missing
// position or an empty table answers without a walk.
// The block takes one word at a time; s_tready is low while a lookup walks or
// while an earlier result word waits without m_tready.
module run_length_index_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// run_length[15:0], position[39:16]
	input  logic [39:0] s_tdata,
	// command[1:0], position_missing[2]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// run_index[7:0], runs_held[16:8], element_total[40:17], zero fill [47:41]
	output logic [47:0] m_tdata,
	// result_missing[0], beyond_end[1], table_full[2]
	output logic [2:0]  m_tuser
);

	logic                                 accept;
	logic [1:0]                           command;
	logic [rli_pkg::IN_LEN_BITS-1:0]      run_length;
	logic [rli_pkg::POS_BITS-1:0]         position;
	logic                                 position_missing;

	logic [rli_pkg::CNT_BITS-1:0]         count_q;
	logic [rli_pkg::TOTAL_BITS-1:0]       total_q;
	logic [rli_pkg::CNT_BITS-1:0]         count_nxt;
	logic [rli_pkg::TOTAL_BITS-1:0]       total_nxt;
	logic [rli_pkg::TOTAL_BITS:0]         total_add;
	logic                                 room;
	logic                                 store_we;
	logic [rli_pkg::RUN_LENGTH_BITS-1:0]  store_wdata;

	logic                                 out_vld_q;
	logic [rli_pkg::RUN_INDEX_BITS-1:0]   out_idx_q;
	logic                                 out_miss_q;
	logic                                 out_beyond_q;
	logic                                 out_full_q;
	logic [rli_pkg::RUNS_HELD_BITS-1:0]   out_held_q;
	logic [rli_pkg::TOTAL_BITS-1:0]       out_total_q;

	rli_pkg::walk_req_t                   walk_req;
	rli_pkg::walk_rsp_t                   walk_rsp;
	logic [rli_pkg::IDX_BITS-1:0]         raddr;
	logic [rli_pkg::RUN_LENGTH_BITS-1:0]  rdata;

	assign command          = s_tuser[1:0];
	assign position_missing = s_tuser[2];
	assign run_length       = s_tdata[15:0];
	assign position         = s_tdata[39:16];

	assign s_tready = !walk_rsp.busy && (!out_vld_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign room        = count_q < rli_pkg::CNT_BITS'(rli_pkg::MAX_RUNS);
	assign store_wdata = rli_pkg::RUN_LENGTH_BITS'(run_length);
	assign store_we    = accept && (command == rli_pkg::CMD_APPEND) && room;
	assign total_add   = {1'b0, total_q} + (rli_pkg::TOTAL_BITS + 1)'(store_wdata);

	always_comb begin
		count_nxt = count_q;
		total_nxt = total_q;
		case (command)
			rli_pkg::CMD_CLEAR: begin
				count_nxt = '0;
				total_nxt = '0;
			end
			rli_pkg::CMD_APPEND: begin
				if (room) begin
					count_nxt = count_q + rli_pkg::CNT_BITS'(1);
					total_nxt = total_add[rli_pkg::TOTAL_BITS] ? rli_pkg::TOTAL_MAX
					                                           : total_add[rli_pkg::TOTAL_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// only a lookup that has runs to visit starts the walk
	assign walk_req.start = accept && (command == rli_pkg::CMD_LOOKUP) && !position_missing
	                        && (count_q != '0);
	assign walk_req.pos   = position;
	assign walk_req.count = count_q;

	rli_store u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[rli_pkg::IDX_BITS-1:0]),
		.wdata (store_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	rli_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (walk_req),
		.rsp    (walk_rsp),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			total_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
				total_q <= total_nxt;
			end
			if ((accept && !walk_req.start) || walk_rsp.done) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walk_rsp.done) begin
			out_idx_q    <= rli_pkg::RUN_INDEX_BITS'(walk_rsp.idx);
			out_miss_q   <= 1'b0;
			out_beyond_q <= walk_rsp.beyond;
			out_full_q   <= 1'b0;
			out_held_q   <= rli_pkg::RUNS_HELD_BITS'(count_q);
			out_total_q  <= total_q;
		end else if (accept && !walk_req.start) begin
			out_idx_q    <= '0;
			out_miss_q   <= 1'b0;
			out_beyond_q <= 1'b0;
			out_full_q   <= 1'b0;
			out_held_q   <= rli_pkg::RUNS_HELD_BITS'(count_nxt);
			out_total_q  <= total_nxt;
			case (command)
				rli_pkg::CMD_APPEND: begin
					out_full_q <= !room;
				end
				rli_pkg::CMD_LOOKUP: begin
					// missing position, or empty table past the end
					out_miss_q   <= position_missing;
					out_beyond_q <= !position_missing;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_total_q, out_held_q, out_idx_q};
	assign m_tuser  = {out_full_q, out_beyond_q, out_miss_q};

endmodule

>>> rtl/rli_store.sv
// run length store: one write port, one registered read port
module rli_store (
	input  logic                                clk,
	input  logic                                we,
	input  logic [rli_pkg::IDX_BITS-1:0]        waddr,
	input  logic [rli_pkg::RUN_LENGTH_BITS-1:0] wdata,
	input  logic [rli_pkg::IDX_BITS-1:0]        raddr,
	output logic [rli_pkg::RUN_LENGTH_BITS-1:0] rdata
);

	logic [rli_pkg::RUN_LENGTH_BITS-1:0] mem_q [rli_pkg::MAX_RUNS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/rli_walk.sv
// lookup sequencer: walks stored runs one per cycle through a shared add and compare
module rli_walk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rli_pkg::walk_req_t                  req,
	output rli_pkg::walk_rsp_t                  rsp,
	output logic [rli_pkg::IDX_BITS-1:0]        raddr,
	input  logic [rli_pkg::RUN_LENGTH_BITS-1:0] rdata
);

	logic                                busy_q;
	logic [rli_pkg::CNT_BITS-1:0]        rd_idx_q;
	logic [rli_pkg::CNT_BITS-1:0]        cnt_q;
	logic [rli_pkg::CNT_BITS-1:0]        last_q;
	logic [rli_pkg::POS_BITS-1:0]        pos_q;
	logic [rli_pkg::ACC_BITS-1:0]        acc_q;
	logic                                vld_s1;
	logic [rli_pkg::IDX_BITS-1:0]        idx_s1;
	logic [rli_pkg::ACC_BITS-1:0]        sum;
	logic                                hit;
	logic                                finish;
	logic                                issue;

	// one shared adder and comparator per visited run
	assign sum    = acc_q + rli_pkg::ACC_BITS'(rdata);
	assign hit    = rli_pkg::CMP_BITS'(sum) > rli_pkg::CMP_BITS'(pos_q);
	assign finish = vld_s1 && (hit || (rli_pkg::CNT_BITS'(idx_s1) == last_q));
	assign issue  = busy_q && !finish && (rd_idx_q < cnt_q);
	assign raddr  = rd_idx_q[rli_pkg::IDX_BITS-1:0];

	assign rsp.busy   = busy_q;
	assign rsp.done   = finish;
	assign rsp.idx    = idx_s1;
	assign rsp.beyond = !hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rd_idx_q <= '0;
			acc_q    <= '0;
			pos_q    <= req.pos;
			cnt_q    <= req.count;
			last_q   <= req.count - rli_pkg::CNT_BITS'(1);
		end else begin
			if (issue) begin
				rd_idx_q <= rd_idx_q + rli_pkg::CNT_BITS'(1);
			end
			if (vld_s1) begin
				acc_q <= sum;
			end
		end
		idx_s1 <= rd_idx_q[rli_pkg::IDX_BITS-1:0];
	end

endmodule

>>> bench/run_length_index_lookup_test.sv
// self-checking testbench for the run length table with element position lookup
`timescale 1ns / 1ps

module run_length_index_lookup_test;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_WORDS  = 150;

	typedef struct packed {
		logic [7:0]  run_index;
		logic        missing;
		logic        beyond;
		logic        full;
		logic [8:0]  runs_held;
		logic [23:0] element_total;
	} answer_t;

	class run_table_scoreboard;
		logic [rli_pkg::RUN_LENGTH_BITS-1:0] stored_lengths [rli_pkg::MAX_RUNS];
		int unsigned                         stored_runs;
		logic [23:0]                         stored_total;
		answer_t                             pending_answers[$];
		int                                  mismatches;

		function new();
			stored_runs  = 0;
			stored_total = '0;
			mismatches   = 0;
		endfunction

		function void note_word(logic [1:0] cmd, logic [15:0] len, logic [23:0] pos,
			logic miss);
			answer_t     a;
			int unsigned acc;
			int unsigned sum;
			bit          found;
			a = '0;
			case (cmd)
				rli_pkg::CMD_CLEAR: begin
					stored_runs  = 0;
					stored_total = '0;
				end
				rli_pkg::CMD_APPEND: begin
					if (stored_runs >= rli_pkg::MAX_RUNS) begin
						a.full = 1'b1;
					end else begin
						stored_lengths[stored_runs] = len;
						stored_runs++;
						sum = stored_total + stored_lengths[stored_runs - 1];
						stored_total = (sum > rli_pkg::TOTAL_MAX) ? rli_pkg::TOTAL_MAX
						                                          : 24'(sum);
					end
				end
				rli_pkg::CMD_LOOKUP: begin
					if (miss) begin
						a.missing = 1'b1;
					end else begin
						acc   = 0;
						found = 0;
						for (int unsigned k = 0; k < stored_runs && !found; k++) begin
							acc += stored_lengths[k];
							if (acc > pos) begin
								a.run_index = 8'(k);
								found       = 1;
							end
						end
						// nothing covers the position: report the last run
						if (!found) begin
							a.beyond    = 1'b1;
							a.run_index = (stored_runs != 0) ? 8'(stored_runs - 1) : 8'd0;
						end
					end
				end
				default: ;
			endcase
			a.runs_held     = 9'(stored_runs);
			a.element_total = stored_total;
			pending_answers.push_back(a);
		endfunction

		function void flag(string what, answer_t want, answer_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: exp idx=%0d miss=%0b beyond=%0b full=%0b runs=%0d total=%0d",
					$realtime, what, want.run_index, want.missing, want.beyond, want.full,
					want.runs_held, want.element_total,
					"\n    got idx=%0d miss=%0b beyond=%0b full=%0b runs=%0d total=%0d",
					got.run_index, got.missing, got.beyond, got.full, got.runs_held,
					got.element_total);
		endfunction

		function void check_word(answer_t got);
			answer_t want;
			if (pending_answers.size() == 0) begin
				flag("result word with nothing pending", '0, got);
			end else begin
				want = pending_answers.pop_front();
				if (got.run_index !== want.run_index || got.missing !== want.missing ||
					got.beyond !== want.beyond || got.full !== want.full ||
					got.runs_held !== want.runs_held ||
					got.element_total !== want.element_total)
					flag("result word mismatch", want, got);
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	run_table_scoreboard board;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_requests = 0;
	int          holds_served  = 0;
	int          hold_left     = 0;
	int          words_sent    = 0;
	int unsigned gen_ends[$];
	int unsigned gen_total     = 0;

	run_length_index_lookup u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served <= holds_served + 1;
			hold_left    <= LONG_HOLD - 1;
			m_tready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: results are checked before the word taken at the same edge is noted
	always @(posedge clk) begin
		answer_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.run_index     = m_tdata[7:0];
				got.runs_held     = m_tdata[16:8];
				got.element_total = m_tdata[40:17];
				got.missing       = m_tuser[0];
				got.beyond        = m_tuser[1];
				got.full          = m_tuser[2];
				board.check_word(got);
			end
			if (s_tvalid && s_tready)
				board.note_word(s_tuser[1:0], s_tdata[15:0], s_tdata[39:16], s_tuser[2]);
		end
	end

	task automatic send_word(logic [1:0] cmd, logic [15:0] len, logic [23:0] pos, logic miss);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 40'({$urandom, $urandom});
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pos, len};
		s_tuser  <= {miss, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cmd != CMD_UNUSED)
			words_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending_answers.size() != 0);
	endtask

	task automatic issue_clear();
		gen_ends.delete();
		gen_total = 0;
		send_word(rli_pkg::CMD_CLEAR, 16'($urandom), 24'($urandom), 1'($urandom));
	endtask

	task automatic issue_append(logic [15:0] len);
		if (gen_ends.size() < rli_pkg::MAX_RUNS) begin
			gen_total = (gen_total + len > rli_pkg::TOTAL_MAX) ? rli_pkg::TOTAL_MAX
			                                                    : gen_total + len;
			gen_ends.push_back(gen_total);
		end
		send_word(rli_pkg::CMD_APPEND, len, 24'($urandom), 1'($urandom));
	endtask

	task automatic issue_lookup(logic [23:0] pos, logic miss);
		send_word(rli_pkg::CMD_LOOKUP, 16'($urandom), pos, miss);
	endtask

	task automatic issue_noise();
		send_word(CMD_UNUSED, 16'($urandom), 24'($urandom), 1'($urandom));
	endtask

	function automatic logic [15:0] random_length();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3, 4: return 16'($urandom);
			default: return 16'($urandom_range(16, 1));
		endcase
	endfunction

	task automatic issue_random_lookup();
		int unsigned pick;
		int unsigned k;
		logic [23:0] pos;
		logic        miss;
		pick = $urandom_range(99);
		miss = 1'b0;
		pos  = 24'($urandom);
		if (pick < 10) begin
			miss = 1'b1;
		end else if (pick < 40 && gen_ends.size() != 0) begin
			// run boundaries: last element of a run or first one after it
			k   = $urandom_range(gen_ends.size() - 1);
			pos = 24'(gen_ends[k] - $urandom_range(1));
		end else if (pick < 75 && gen_total != 0) begin
			pos = 24'($urandom_range(gen_total - 1));
		end else if (pick < 90) begin
			pos = 24'(gen_total + $urandom_range(3));
		end
		issue_lookup(pos, miss);
	endtask

	task automatic run_small_episode();
		int unsigned n;
		if ($urandom_range(99) < 75 || gen_ends.size() > 200)
			issue_clear();
		n = $urandom_range(12);
		repeat (n) issue_append(random_length());
		n = $urandom_range(8, 1);
		repeat (n) begin
			case ($urandom_range(19))
				0: issue_noise();
				1: issue_append(random_length());
				default: issue_random_lookup();
			endcase
		end
	endtask

	task automatic run_full_episode();
		issue_clear();
		// a few appends past capacity are dropped
		repeat (rli_pkg::MAX_RUNS + 3) issue_append(random_length());
		repeat (12) issue_random_lookup();
	endtask

	initial begin
		int phase_goal;
		board = new();
		send_idle_pct = 37;
		recv_idle_pct = 48;
		wait (arst_n === 1'b1);
		@(posedge clk);

		issue_lookup(24'd0, 1'b0);
		issue_lookup(24'hFFFFFF, 1'b1);
		send_word(CMD_UNUSED, 16'hFFFF, 24'hFFFFFF, 1'b1);
		issue_append(16'd0);
		issue_append(16'hFFFF);
		issue_append(16'd1);
		issue_lookup(24'd0, 1'b0);
		issue_lookup(24'hFFFE, 1'b0);
		issue_lookup(24'hFFFF, 1'b0);
		issue_lookup(24'h10000, 1'b0);
		issue_lookup(24'hFFFFFF, 1'b0);
		issue_lookup(24'd3, 1'b1);
		issue_append(16'h8000);
		issue_lookup(24'h10000, 1'b0);
		send_word(rli_pkg::CMD_CLEAR, 16'hFFFF, 24'hFFFFFF, 1'b1);
		issue_lookup(24'd0, 1'b0);
		issue_append(16'd7);
		issue_lookup(24'd6, 1'b0);
		issue_lookup(24'd7, 1'b0);
		send_word(CMD_UNUSED, 16'd0, 24'd0, 1'b0);
		issue_clear();
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 37 : 0;
			// block fills up behind a long receiver hold-off
			if (phase == 2)
				hold_requests <= hold_requests + 1;
			phase_goal = words_sent + PHASE_WORDS;
			if (phase == 1)
				run_full_episode();
			while (words_sent < phase_goal) begin
				run_small_episode();
				if ($urandom_range(9) == 0)
					wait_drained();
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending_answers.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
